// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the motor drive.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CHK(lbl, !(cond))

`endif

// ----- hdl/pdcmd_pkg.sv -----
// Shared constants and types for the PD / current motor drive.
// No dependencies.
`default_nettype none

package pdcmd_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegControlMode    = 3'd0,
    RegGainPosition   = 3'd1,
    RegGainDamping    = 3'd2,
    RegGainCurrent    = 3'd3,
    RegDutyUpperLimit = 3'd4,
    RegDutyLowerLimit = 3'd5
  } cfg_reg_e;

  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 16;
  localparam int PosW      = 32;  // position and velocity fields
  localparam int CurW      = 16;  // current fields and gains
  localparam int LimitW    = 15;  // duty limits
  localparam int DutyW     = 16;
  localparam int InDataW   = 4 * PosW + 2 * CurW;

  localparam logic                     ModeRst       = 1'b1;  // current control
  localparam logic        [LimitW-1:0] DutyUpperRst  = 15'd16384;
  localparam logic signed [LimitW-1:0] DutyLowerRst  = 15'sh4000;  // -16384

  localparam logic signed [CurW-1:0]   SenseNearZero = 16'sd2;

endpackage

`default_nettype wire

// ----- hdl/pd_current_motor_drive.sv -----
// PD / current motor drive, one channel.
// A word accepted on s_axis passes through the input register, the error/product
// stage and the state update and output register before its duty is on m_axis.
// Throughput: one word per clock unless m_axis_tready stalls it; the torque and
// accumulator state live only in the last stage, so consecutive words chain with no gap.
// Reset (rst_ni low, asynchronous): pipeline empties, state and registers to defaults.
`default_nettype none
`include "assert_macros.svh"

module pd_current_motor_drive #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [pdcmd_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  wire logic [pdcmd_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // input word
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // goal_position, goal_velocity, measured_position, measured_velocity,
  // goal_current, sensed_current (from bit 0 up)
  input  wire logic [pdcmd_pkg::InDataW-1:0]        s_axis_tdata,
  // result word
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // duty
  output      logic [pdcmd_pkg::DutyW-1:0]          m_axis_tdata
);

  localparam int TW = FRACTION_BITS + 2;         // torque, signed, spans +/- one
  localparam int EW = pdcmd_pkg::PosW + 1;       // full precision position error
  localparam int PPW = TW + pdcmd_pkg::CurW;     // k * perr
  localparam int VPW = EW + pdcmd_pkg::CurW;     // b * verr
  localparam int SW = VPW + 6;                   // 32 * b * verr + k * perr
  localparam int CW = 2 * pdcmd_pkg::CurW;       // a * current error
  localparam int AW = pdcmd_pkg::CurW + 2;       // accumulator sum

  localparam logic signed [TW-1:0] OneT = {2'b01, {FRACTION_BITS{1'b0}}};
  localparam logic signed [TW-1:0] MinT = {2'b11, {FRACTION_BITS{1'b0}}};
  localparam logic signed [TW:0]   OneE = {3'b001, {FRACTION_BITS{1'b0}}};
  localparam logic signed [pdcmd_pkg::CurW-1:0] ErrCap =
    pdcmd_pkg::CurW'(1 << (FRACTION_BITS - 4));
  localparam logic signed [AW-1:0] Max16 = 18'sd32767;
  localparam logic signed [AW-1:0] Min16 = -18'sd32768;
  localparam logic signed [CW-1:0] Max16W = 32'sd32767;
  localparam logic signed [CW-1:0] Min16W = -32'sd32768;

  typedef struct packed {
    logic signed [TW-1:0]                 torque;
    logic signed [pdcmd_pkg::CurW-1:0]    cur_err;
    logic                                 cur_clr;
    logic                                 cur_pos;
    logic                                 cur_neg;
  } stage_a_t;

  // ---------------------------------------------------------------- config
  logic                                   mode_q;
  logic signed [pdcmd_pkg::CurW-1:0]      gain_pos_q, gain_damp_q, gain_cur_q;
  logic        [pdcmd_pkg::LimitW-1:0]    duty_up_q;
  logic signed [pdcmd_pkg::LimitW-1:0]    duty_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pdcmd_pkg::ModeRst;
      gain_pos_q  <= '0;
      gain_damp_q <= '0;
      gain_cur_q  <= '0;
      duty_up_q   <= pdcmd_pkg::DutyUpperRst;
      duty_lo_q   <= pdcmd_pkg::DutyLowerRst;
    end else if (cfg_we_i) begin
      unique case (pdcmd_pkg::cfg_reg_e'(cfg_addr_i))
        pdcmd_pkg::RegControlMode:    mode_q      <= cfg_wdata_i[0];
        pdcmd_pkg::RegGainPosition:   gain_pos_q  <= $signed(cfg_wdata_i);
        pdcmd_pkg::RegGainDamping:    gain_damp_q <= $signed(cfg_wdata_i);
        pdcmd_pkg::RegGainCurrent:    gain_cur_q  <= $signed(cfg_wdata_i);
        pdcmd_pkg::RegDutyUpperLimit: duty_up_q   <= cfg_wdata_i[pdcmd_pkg::LimitW-1:0];
        pdcmd_pkg::RegDutyLowerLimit:
          duty_lo_q <= $signed(cfg_wdata_i[pdcmd_pkg::LimitW-1:0]);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  logic v0_q, v1_q, v2_q;
  logic en1, en2;

  assign en2           = !v2_q || m_axis_tready;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = !v0_q || en1;
  assign m_axis_tvalid = v2_q;

  // ---------------------------------------------------------- input stage
  logic signed [pdcmd_pkg::PosW-1:0] gp_q, gv_q, mp_q, mv_q;
  logic signed [pdcmd_pkg::CurW-1:0] gc_q, sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      gp_q <= $signed(s_axis_tdata[31:0]);
      gv_q <= $signed(s_axis_tdata[63:32]);
      mp_q <= $signed(s_axis_tdata[95:64]);
      mv_q <= $signed(s_axis_tdata[127:96]);
      gc_q <= $signed(s_axis_tdata[143:128]);
      sc_q <= $signed(s_axis_tdata[159:144]);
    end
  end

  // ------------------------------------------- errors, products, clamps
  logic signed [EW-1:0]  perr, verr;
  logic signed [TW-1:0]  perr_n;
  logic signed [PPW-1:0] prod_p;
  logic signed [VPW-1:0] prod_v;
  logic signed [SW-1:0]  pd_sum, pd_shr;
  logic                  k_pos;
  logic signed [TW-1:0]  torque_a;

  logic signed [AW-1:0]  cerr_w;
  logic signed [pdcmd_pkg::CurW-1:0] cerr16, cerr_s;
  logic signed [CW-1:0]  prod_c, prod_c_shr;
  logic                  tgt_pos, tgt_neg, near_zero;
  stage_a_t              sa_d, sa_q;

  assign perr   = EW'(gp_q) - EW'(mp_q);
  assign verr   = EW'(gv_q) - EW'(mv_q);
  assign perr_n = $signed(perr[TW-1:0]);   // only used while |perr| <= one
  assign prod_p = PPW'(gain_pos_q) * PPW'(perr_n);
  assign prod_v = VPW'(gain_damp_q) * VPW'(verr);
  assign pd_sum = SW'(prod_p) + (SW'(prod_v) <<< 5);
  assign pd_shr = pd_sum >>> (FRACTION_BITS - 4);
  assign k_pos  = !gain_pos_q[pdcmd_pkg::CurW-1] && (|gain_pos_q);

  always_comb begin
    priority if (perr > EW'(OneT)) begin
      torque_a = k_pos ? OneT : MinT;
    end else if (perr < EW'(MinT)) begin
      torque_a = k_pos ? MinT : OneT;
    end else if (pd_shr > SW'(OneT)) begin
      torque_a = OneT;
    end else if (pd_shr < SW'(MinT)) begin
      torque_a = MinT;
    end else begin
      torque_a = $signed(pd_shr[TW-1:0]);
    end
  end

  // current loop error: drive direction from the sign of the target
  assign tgt_pos = !gc_q[pdcmd_pkg::CurW-1] && (|gc_q);
  assign tgt_neg = gc_q[pdcmd_pkg::CurW-1];

  always_comb begin
    priority if (tgt_pos) begin
      cerr_w = AW'(gc_q) - AW'(sc_q);
    end else if (tgt_neg) begin
      cerr_w = -AW'(gc_q) - AW'(sc_q);
    end else begin
      cerr_w = '0;
    end
  end

  always_comb begin
    priority if (cerr_w > Max16) begin
      cerr16 = Max16[pdcmd_pkg::CurW-1:0];
    end else if (cerr_w < Min16) begin
      cerr16 = Min16[pdcmd_pkg::CurW-1:0];
    end else begin
      cerr16 = cerr_w[pdcmd_pkg::CurW-1:0];
    end
  end

  assign prod_c     = CW'(cerr16) * CW'(gain_cur_q);
  assign prod_c_shr = prod_c >>> FRACTION_BITS;

  always_comb begin
    priority if (prod_c_shr > Max16W) begin
      cerr_s = Max16W[pdcmd_pkg::CurW-1:0];
    end else if (prod_c_shr < Min16W) begin
      cerr_s = Min16W[pdcmd_pkg::CurW-1:0];
    end else begin
      cerr_s = prod_c_shr[pdcmd_pkg::CurW-1:0];
    end
  end

  // near-zero sense restarts the integrator with a capped error
  assign near_zero = (sc_q < pdcmd_pkg::SenseNearZero) && (cerr_s > ErrCap);

  always_comb begin
    sa_d.torque  = torque_a;
    sa_d.cur_err = near_zero ? ErrCap : cerr_s;
    sa_d.cur_clr = near_zero;
    sa_d.cur_pos = tgt_pos;
    sa_d.cur_neg = tgt_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      sa_q <= sa_d;
    end
  end

  // ------------------------------------- slew, integrator, duty limits
  logic signed [TW-1:0]  prev_q;
  logic signed [pdcmd_pkg::CurW-1:0] acc_q;
  logic signed [TW:0]    step, prev_ext, prev_up, prev_dn;
  logic signed [TW-1:0]  torque_n;
  logic signed [AW-1:0]  acc_base, acc_delta, acc_sum, acc_sat, acc_dir;
  logic signed [pdcmd_pkg::CurW-1:0] acc_n;
  logic signed [AW-1:0]  duty_raw, duty_up, duty_lo, duty_hi_cl, duty_cl;
  logic        [pdcmd_pkg::DutyW-1:0] duty_q;

  assign prev_ext = (TW + 1)'(prev_q);
  assign step     = (TW + 1)'(sa_q.torque) - prev_ext;
  assign prev_up  = prev_ext + OneE;
  assign prev_dn  = prev_ext - OneE;

  always_comb begin
    priority if (step > OneE) begin
      torque_n = prev_up[TW-1:0];
    end else if (step < -OneE) begin
      torque_n = prev_dn[TW-1:0];
    end else begin
      torque_n = sa_q.torque;
    end
  end

  assign acc_base = sa_q.cur_clr ? '0 : AW'(acc_q);

  always_comb begin
    priority if (sa_q.cur_pos) begin
      acc_delta = AW'(sa_q.cur_err);
    end else if (sa_q.cur_neg) begin
      acc_delta = -AW'(sa_q.cur_err);
    end else begin
      acc_delta = '0;
    end
  end

  assign acc_sum = acc_base + acc_delta;

  always_comb begin
    priority if (acc_sum > Max16) begin
      acc_sat = Max16;
    end else if (acc_sum < Min16) begin
      acc_sat = Min16;
    end else begin
      acc_sat = acc_sum;
    end
  end

  always_comb begin
    acc_dir = '0;
    if (sa_q.cur_pos) begin
      priority if (acc_sat < 0) begin
        acc_dir = '0;
      end else if (acc_sat > AW'(OneT)) begin
        acc_dir = AW'(OneT);
      end else begin
        acc_dir = acc_sat;
      end
    end else if (sa_q.cur_neg) begin
      priority if (acc_sat > 0) begin
        acc_dir = '0;
      end else if (acc_sat < AW'(MinT)) begin
        acc_dir = AW'(MinT);
      end else begin
        acc_dir = acc_sat;
      end
    end
  end

  assign acc_n = acc_dir[pdcmd_pkg::CurW-1:0];

  // upper limit first, lower limit last so it wins when they cross
  assign duty_raw   = mode_q ? AW'(acc_n) : AW'(torque_n);
  assign duty_up    = $signed({3'b000, duty_up_q});
  assign duty_lo    = AW'(duty_lo_q);
  assign duty_hi_cl = (duty_raw > duty_up) ? duty_up : duty_raw;
  assign duty_cl    = (duty_hi_cl < duty_lo) ? duty_lo : duty_hi_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      prev_q <= '0;
      acc_q  <= '0;
    end else begin
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en2 && v1_q) begin
        if (mode_q) begin
          acc_q <= acc_n;
        end else begin
          prev_q <= torque_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      duty_q <= duty_cl[pdcmd_pkg::DutyW-1:0];
    end
  end

  assign m_axis_tdata = duty_q;

  // ------------------------------------------------------------ checks
  `ASSERT_CHK(a_prev_range, (prev_ext <= OneE) && (prev_ext >= -OneE))
  `ASSERT_CHK(a_slew_step, (en2 && v1_q && !mode_q) |=>
    ((prev_ext - $past(prev_ext)) <= OneE) && ((prev_ext - $past(prev_ext)) >= -OneE))
  `ASSERT_NEVER(a_acc_below_one, AW'(acc_q) < AW'(MinT))

endmodule

`default_nettype wire
